@@ design/ptm_pkg.sv @@
`default_nettype none
package ptm_pkg;

    typedef struct packed {
        logic        opcode;
        logic [14:0] phase_step;
        logic [19:0] duration_samples;
        logic [14:0] amplitude;
    } t_in_item;

    typedef struct packed {
        logic               is_sample;
        logic signed [15:0] sample_out;
        logic               tone_accepted;
        logic [3:0]         voices_active;
    } t_out_item;

    localparam logic       OP_START = 1'b0;
    localparam logic       OP_TICK  = 1'b1;

    localparam logic [1:0] REG_FADE  = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_KNEE  = 2'd2;

    localparam logic [15:0] FADE_RESET = 16'd480;
    localparam logic [14:0] GAIN_RESET = 15'd26214;
    localparam logic [14:0] KNEE_RESET = 15'd26214;

    // Quarter-wave sine, round(32767*sin(k*pi/64)) for k = 0..32.
    function automatic logic [14:0] sine_quarter(input logic [5:0] k);
        logic [14:0] v;
        unique case (k)
            6'd0:  v = 15'd0;     6'd1:  v = 15'd1608;  6'd2:  v = 15'd3212;
            6'd3:  v = 15'd4808;  6'd4:  v = 15'd6393;  6'd5:  v = 15'd7962;
            6'd6:  v = 15'd9512;  6'd7:  v = 15'd11039; 6'd8:  v = 15'd12539;
            6'd9:  v = 15'd14010; 6'd10: v = 15'd15446; 6'd11: v = 15'd16846;
            6'd12: v = 15'd18204; 6'd13: v = 15'd19519; 6'd14: v = 15'd20787;
            6'd15: v = 15'd22005; 6'd16: v = 15'd23170; 6'd17: v = 15'd24279;
            6'd18: v = 15'd25329; 6'd19: v = 15'd26319; 6'd20: v = 15'd27245;
            6'd21: v = 15'd28105; 6'd22: v = 15'd28898; 6'd23: v = 15'd29621;
            6'd24: v = 15'd30273; 6'd25: v = 15'd30852; 6'd26: v = 15'd31356;
            6'd27: v = 15'd31785; 6'd28: v = 15'd32137; 6'd29: v = 15'd32412;
            6'd30: v = 15'd32609; 6'd31: v = 15'd32728;
            default: v = 15'd32767;
        endcase
        return v;
    endfunction

    // round(32768/sqrt(n)), with 32768 meaning unity.
    function automatic logic [15:0] inv_sqrt(input logic [5:0] n);
        logic [15:0] v;
        unique case (n)
            6'd0:  v = 16'd32768; 6'd1:  v = 16'd32768; 6'd2:  v = 16'd23170;
            6'd3:  v = 16'd18919; 6'd4:  v = 16'd16384; 6'd5:  v = 16'd14654;
            6'd6:  v = 16'd13377; 6'd7:  v = 16'd12385; 6'd8:  v = 16'd11585;
            6'd9:  v = 16'd10923; 6'd10: v = 16'd10362; 6'd11: v = 16'd9880;
            6'd12: v = 16'd9459;  6'd13: v = 16'd9088;  6'd14: v = 16'd8758;
            6'd15: v = 16'd8461;  6'd16: v = 16'd8192;  6'd17: v = 16'd7947;
            6'd18: v = 16'd7723;  6'd19: v = 16'd7517;  6'd20: v = 16'd7327;
            6'd21: v = 16'd7151;  6'd22: v = 16'd6986;  6'd23: v = 16'd6833;
            6'd24: v = 16'd6689;  6'd25: v = 16'd6554;  6'd26: v = 16'd6426;
            6'd27: v = 16'd6306;  6'd28: v = 16'd6193;  6'd29: v = 16'd6085;
            6'd30: v = 16'd5983;  6'd31: v = 16'd5885;
            default: v = 16'd5793;
        endcase
        return v;
    endfunction

    // tanh sampled at 17 points over [0,1] in Q1.15.
    function automatic logic [14:0] tanh_q15(input logic [4:0] s);
        logic [14:0] v;
        unique case (s)
            5'd0:  v = 15'd0;     5'd1:  v = 15'd2045;  5'd2:  v = 15'd4075;
            5'd3:  v = 15'd6073;  5'd4:  v = 15'd8025;  5'd5:  v = 15'd9919;
            5'd6:  v = 15'd11743; 5'd7:  v = 15'd13486; 5'd8:  v = 15'd15143;
            5'd9:  v = 15'd16706; 5'd10: v = 15'd18173; 5'd11: v = 15'd19542;
            5'd12: v = 15'd20813; 5'd13: v = 15'd21986; 5'd14: v = 15'd23066;
            5'd15: v = 15'd24054;
            default: v = 15'd24956;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ design/ptm_cell.sv @@
`default_nettype none
// One voice slot of the ring. On a shift it takes its neighbor's record,
// advanced by one sample when the record has just been played.
module ptm_cell
    import ptm_pkg::*;
#(
    parameter int PHASE_BITS    = 16,
    parameter int DURATION_BITS = 20
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_shift,
    input  wire logic                     i_advance,
    input  wire logic                     i_active,
    input  wire logic [PHASE_BITS-1:0]    i_phase,
    input  wire logic [14:0]              i_step,
    input  wire logic [DURATION_BITS-1:0] i_remaining,
    input  wire logic [14:0]              i_level,
    output logic                          o_active,
    output logic [PHASE_BITS-1:0]         o_phase,
    output logic [14:0]                   o_step,
    output logic [DURATION_BITS-1:0]      o_remaining,
    output logic [14:0]                   o_level
);

    localparam int SW = (PHASE_BITS > 15) ? PHASE_BITS : 15;

    logic                     r_active;
    logic [PHASE_BITS-1:0]    r_phase;
    logic [14:0]              r_step;
    logic [DURATION_BITS-1:0] r_remaining;
    logic [14:0]              r_level;
    logic [SW-1:0]            w_sum;
    logic                     w_last;

    assign w_sum  = SW'(i_phase) + SW'(i_step);
    assign w_last = (i_remaining <= DURATION_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_shift) begin
            r_active <= i_advance ? (i_active && !w_last) : i_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_step  <= i_step;
            r_level <= i_level;
            if (i_advance) begin
                r_phase     <= w_sum[PHASE_BITS-1:0];
                r_remaining <= i_remaining - DURATION_BITS'(1);
            end else begin
                r_phase     <= i_phase;
                r_remaining <= i_remaining;
            end
        end
    end

    assign o_active    = r_active;
    assign o_phase     = r_phase;
    assign o_step      = r_step;
    assign o_remaining = r_remaining;
    assign o_level     = r_level;

endmodule
`default_nettype wire

@@ design/ptm_div.sv @@
`default_nettype none
// Restoring divider with a 31-bit quotient, one quotient bit per cycle.
module ptm_div
    import ptm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [30:0] i_num,
    input  wire logic [15:0] i_den,
    output logic             o_busy,
    output logic [30:0]      o_quot
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [30:0] r_num;
    logic [15:0] r_den;
    logic [16:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_num[30]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd30) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? 16'(w_trial - {1'b0, r_den}) : w_trial[15:0];
            r_num <= {r_num[29:0], w_ge};
        end
    end

    assign o_busy = r_busy | i_start;
    assign o_quot = r_num;

endmodule
`default_nettype wire

@@ design/polyphonic_tone_mixer.sv @@
`default_nettype none
// Polyphonic tone mixer with soft clip.
// Items arrive on a valid/ready input channel. An item with opcode start
// loads a tone into the lowest free voice slot; an item with opcode tick
// mixes one output sample from every active voice. Each item gives exactly
// one result item on the valid/ready output channel.
// A start item takes one full turn of the voice ring. A tick passes every
// voice slot, with more steps for each active voice and a division for each
// voice inside its fade and for a mix above the knee, since the fade and the
// soft clip share one divider that yields one bit per cycle.
// One item is worked on at a time; the input is ready again once the
// result sits in the output register, so the next item is taken while
// that result still waits for the receiver. A stalled receiver holds the
// result and, after one more item has finished, stops the input.
// Reset clears all voices and loads the register defaults; no clearing
// pass is needed. The APB port writes fade length, headroom gain and knee.
module polyphonic_tone_mixer
    import ptm_pkg::*;
#(
    parameter int MAX_VOICES    = 8,
    parameter int PHASE_BITS    = 16,
    parameter int DURATION_BITS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = $clog2(MAX_VOICES + 1);
    localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam logic [32:0] DUR_MAX = (33'd1 << DURATION_BITS) - 33'd1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_VA, ST_VB, ST_VWAIT, ST_VN, ST_VG, ST_VACC,
        ST_CLIP, ST_CWAIT, ST_CT, ST_CY, ST_FIN
    } t_state;

    // Configuration registers.
    logic [15:0] r_fade;
    logic [14:0] r_gain;
    logic [14:0] r_knee;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade <= FADE_RESET;
            r_gain <= GAIN_RESET;
            r_knee <= KNEE_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_FADE: r_fade <= pwdata[15:0];
                REG_GAIN: r_gain <= pwdata[14:0];
                REG_KNEE: r_knee <= pwdata[14:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FADE: prdata = {16'd0, r_fade};
            REG_GAIN: prdata = {17'd0, r_gain};
            REG_KNEE: prdata = {17'd0, r_knee};
            default:  prdata = 32'd0;
        endcase
    end
    assign pready = 1'b1;

    // Voice ring: slot 0 sits at the head, and a full turn of MAX_VOICES
    // shifts brings every record back to its own slot.
    logic                     w_act   [MAX_VOICES];
    logic [PHASE_BITS-1:0]    w_phase [MAX_VOICES];
    logic [14:0]              w_step  [MAX_VOICES];
    logic [DURATION_BITS-1:0] w_rem   [MAX_VOICES];
    logic [14:0]              w_level [MAX_VOICES];

    logic                     w_shift;
    logic                     w_adv;
    logic                     w_load;
    logic                     w_in_act;
    logic [PHASE_BITS-1:0]    w_in_phase;
    logic [14:0]              w_in_step;
    logic [DURATION_BITS-1:0] w_in_rem;
    logic [14:0]              w_in_level;

    t_state                   r_state;
    t_in_item                 r_item;
    logic [DURATION_BITS-1:0] r_dur;
    logic                     r_placed;
    logic [VW-1:0]            r_vcnt;
    logic [CW-1:0]            r_count;
    logic [15:0]              r_norm;
    logic [14:0]              r_mag;
    logic                     r_neg;
    logic signed [16:0]       r_acc;
    logic                     r_sign;
    logic [14:0]              r_th;
    logic [15:0]              r_y;
    t_out_item                r_res;
    logic                     r_ovalid;
    t_out_item                r_out;
    logic                     r_div_start;
    logic [30:0]              r_div_num;
    logic [15:0]              r_div_den;

    assign w_load = (r_state == ST_START) && !r_placed && !w_act[0];
    assign w_adv  = (r_state == ST_VACC);
    assign w_shift = (r_state == ST_START) || w_adv || ((r_state == ST_VA) && !w_act[0]);

    always_comb begin
        if (w_load) begin
            w_in_act   = 1'b1;
            w_in_phase = '0;
            w_in_step  = r_item.phase_step;
            w_in_rem   = r_dur;
            w_in_level = r_item.amplitude;
        end else begin
            w_in_act   = w_act[0];
            w_in_phase = w_phase[0];
            w_in_step  = w_step[0];
            w_in_rem   = w_rem[0];
            w_in_level = w_level[0];
        end
    end

    for (genvar g = 0; g < MAX_VOICES; g++) begin : g_cell
        logic                     c_act;
        logic [PHASE_BITS-1:0]    c_phase;
        logic [14:0]              c_step;
        logic [DURATION_BITS-1:0] c_rem;
        logic [14:0]              c_level;
        if (g == MAX_VOICES - 1) begin : g_tail
            assign c_act   = w_in_act;
            assign c_phase = w_in_phase;
            assign c_step  = w_in_step;
            assign c_rem   = w_in_rem;
            assign c_level = w_in_level;
        end else begin : g_link
            assign c_act   = w_act[g+1];
            assign c_phase = w_phase[g+1];
            assign c_step  = w_step[g+1];
            assign c_rem   = w_rem[g+1];
            assign c_level = w_level[g+1];
        end
        ptm_cell #(
            .PHASE_BITS    (PHASE_BITS),
            .DURATION_BITS (DURATION_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (w_shift),
            .i_advance   ((g == MAX_VOICES - 1) ? w_adv : 1'b0),
            .i_active    (c_act),
            .i_phase     (c_phase),
            .i_step      (c_step),
            .i_remaining (c_rem),
            .i_level     (c_level),
            .o_active    (w_act[g]),
            .o_phase     (w_phase[g]),
            .o_step      (w_step[g]),
            .o_remaining (w_rem[g]),
            .o_level     (w_level[g])
        );
    end

    // Shared divider for the fade and the soft clip.
    logic        w_div_busy;
    logic [30:0] w_quot;

    ptm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Datapath terms of the head voice.
    logic [6:0]  w_idx;
    logic [14:0] w_sine;
    logic [32:0] w_rem33;
    logic        w_fading;
    logic        w_freed;
    logic [29:0] w_p_level;
    logic [30:0] w_p_norm;
    logic [29:0] w_p_gain;
    logic signed [16:0] w_sum;
    logic signed [16:0] w_sum_c;
    logic [14:0] w_m;
    logic [15:0] w_h;
    logic [32:0] w_d33;
    logic [32:0] w_dsat;
    logic [14:0] w_t;
    logic [14:0] w_tlo;
    logic [14:0] w_thi;
    logic [22:0] w_interp;
    logic [30:0] w_p_h;
    logic [16:0] w_y;
    logic        w_last_v;
    logic [CW-1:0] w_count_start;
    logic        w_fin_go;

    assign w_idx    = w_phase[0][PHASE_BITS-1 -: 7];
    assign w_sine   = w_idx[5] ? sine_quarter(6'd32 - {1'b0, w_idx[4:0]})
                               : sine_quarter({1'b0, w_idx[4:0]});
    assign w_rem33  = 33'(w_rem[0]);
    assign w_fading = (w_rem33 < 33'(r_fade));
    assign w_freed  = w_act[0] && (w_rem[0] <= DURATION_BITS'(1));
    assign w_p_level = w_sine * w_level[0];
    assign w_p_norm  = r_mag * r_norm;
    assign w_p_gain  = r_mag * r_gain;
    assign w_sum     = r_acc + (r_neg ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag}));
    assign w_sum_c   = (w_sum > 17'sd32767) ? 17'sd32767 :
                       (w_sum < -17'sd32767) ? -17'sd32767 : w_sum;
    assign w_m       = r_acc[16] ? 15'(-r_acc) : r_acc[14:0];
    assign w_h       = 16'd32768 - {1'b0, r_knee};
    assign w_d33     = 33'(i_in_data.duration_samples);
    assign w_dsat    = (w_d33 > DUR_MAX) ? DUR_MAX : w_d33;
    assign w_t       = (w_quot > 31'd32767) ? 15'd32767 : w_quot[14:0];
    assign w_tlo     = tanh_q15({1'b0, w_t[14:11]});
    assign w_thi     = tanh_q15(5'({1'b0, w_t[14:11]} + 5'd1));
    assign w_interp  = (w_thi - w_tlo) * w_t[10:0];
    assign w_p_h     = w_h * r_th;
    assign w_y       = {2'b00, r_knee} + {1'b0, w_p_h[30:15]};
    assign w_last_v  = (r_vcnt == VW'(MAX_VOICES - 1));
    assign w_count_start = r_count + CW'(r_placed | w_load);
    // The finished result moves to the output register when it is free or
    // is being taken in this cycle.
    assign w_fin_go  = (r_state == ST_FIN) && (!r_ovalid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= ((r_state == ST_VB) && w_fading) ||
                           ((r_state == ST_CLIP) && (w_m > r_knee));
            if (w_fin_go) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_item   <= i_in_data;
                        r_dur    <= w_dsat[DURATION_BITS-1:0];
                        r_placed <= 1'b0;
                        r_vcnt   <= '0;
                        r_acc    <= '0;
                        r_norm   <= inv_sqrt(6'(r_count));
                        r_state  <= (i_in_data.opcode == OP_TICK) ? ST_VA : ST_START;
                    end
                end
                ST_START: begin
                    if (w_load) begin
                        r_placed <= 1'b1;
                    end
                    r_vcnt <= r_vcnt + VW'(1);
                    if (w_last_v) begin
                        r_count <= w_count_start;
                        r_res   <= '{is_sample: 1'b0, sample_out: 16'sd0,
                                     tone_accepted: r_placed | w_load,
                                     voices_active: 4'(w_count_start)};
                        r_state <= ST_FIN;
                    end
                end
                ST_VA: begin
                    if (w_act[0]) begin
                        r_mag   <= w_p_level[29:15];
                        r_neg   <= w_idx[6];
                        r_state <= ST_VB;
                    end else begin
                        r_vcnt  <= r_vcnt + VW'(1);
                        r_state <= w_last_v ? ST_CLIP : ST_VA;
                    end
                end
                ST_VB: begin
                    if (w_fading) begin
                        r_div_num   <= r_mag * w_rem33[15:0];
                        r_div_den   <= r_fade;
                        r_state     <= ST_VWAIT;
                    end else begin
                        r_state <= ST_VN;
                    end
                end
                ST_VWAIT: begin
                    if (!w_div_busy) begin
                        r_mag   <= w_quot[14:0];
                        r_state <= ST_VN;
                    end
                end
                ST_VN: begin
                    r_mag   <= w_p_norm[29:15];
                    r_state <= ST_VG;
                end
                ST_VG: begin
                    r_mag   <= w_p_gain[29:15];
                    r_state <= ST_VACC;
                end
                ST_VACC: begin
                    r_acc  <= w_sum_c;
                    r_vcnt <= r_vcnt + VW'(1);
                    if (w_freed) begin
                        r_count <= r_count - CW'(1);
                    end
                    r_state <= w_last_v ? ST_CLIP : ST_VA;
                end
                ST_CLIP: begin
                    r_sign <= r_acc[16];
                    if (w_m <= r_knee) begin
                        r_y     <= {1'b0, w_m};
                        r_state <= ST_CY;
                    end else begin
                        r_div_num   <= {1'b0, w_m - r_knee, 15'd0};
                        r_div_den   <= w_h;
                        r_state     <= ST_CWAIT;
                    end
                end
                ST_CWAIT: begin
                    if (!w_div_busy) begin
                        r_th    <= w_tlo + 15'(w_interp[22:11]);
                        r_state <= ST_CT;
                    end
                end
                ST_CT: begin
                    r_y     <= (w_y > 17'd32767) ? 16'd32767 : w_y[15:0];
                    r_state <= ST_CY;
                end
                ST_CY: begin
                    r_res   <= '{is_sample: 1'b1,
                                 sample_out: r_sign ? -$signed(r_y) : $signed(r_y),
                                 tone_accepted: 1'b0,
                                 voices_active: 4'(r_count)};
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (w_fin_go) begin
                        r_out    <= r_res;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
